// ===== hw/rtl/rqds_pkg.sv =====
// types and constants shared by the ready queue dispatch selector
`default_nettype none

package rqds_pkg;

    localparam logic       CMD_ENQUEUE  = 1'b0;
    localparam logic       CMD_SCHEDULE = 1'b1;

    localparam logic [1:0] POLICY_FCFS  = 2'd0;
    localparam logic [1:0] POLICY_EDF   = 2'd1;
    localparam logic [1:0] POLICY_RM    = 2'd2;

    typedef struct packed {
        logic        command;
        logic [3:0]  task_id;
        logic [31:0] task_deadline;
        logic [31:0] task_period;
        logic        cpu_busy;
    } t_in_item;

    typedef struct packed {
        logic       dispatch_valid;
        logic [3:0] dispatched_task;
        logic [3:0] queue_count;
        logic       enqueue_dropped;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  task_id;
        logic [31:0] deadline;
        logic [31:0] period;
    } t_entry;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_eng_res;

endpackage

`default_nettype wire

// ===== hw/rtl/rqds_if.sv =====
// valid/ready channel interfaces for input items and results
`default_nettype none

interface rqds_in_if;
    logic               valid;
    logic               ready;
    rqds_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rqds_out_if;
    logic                valid;
    logic                ready;
    rqds_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rqds_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module rqds_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rqds_engine.sv =====
// queue sequencer: append, minimum scan and close-up over the entry ram
`default_nettype none

module rqds_engine #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire rqds_pkg::t_in_item  i_in_item,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_policy,
    output rqds_pkg::t_eng_res       o_res,
    input  wire logic                i_res_take
);
    import rqds_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_rd_ptr, n_rd_ptr;
    logic          r_dv, n_dv;
    logic [AW-1:0] r_dv_ptr, n_dv_ptr;
    logic [CW-1:0] r_scan_len, n_scan_len;
    logic          r_key_sel, n_key_sel;
    logic [31:0]   r_best_key, n_best_key;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic [3:0]    r_best_task, n_best_task;
    t_out_item     r_res, n_res;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    t_entry               ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry               rd_entry;
    logic [31:0]          rd_key;

    rqds_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign rd_key   = r_key_sel ? rd_entry.deadline : rd_entry.period;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd_ptr    = r_rd_ptr;
        n_dv        = 1'b0;
        n_dv_ptr    = r_dv_ptr;
        n_scan_len  = r_scan_len;
        n_key_sel   = r_key_sel;
        n_best_key  = r_best_key;
        n_best_idx  = r_best_idx;
        n_best_task = r_best_task;
        n_res       = r_res;

        ram_we             = 1'b0;
        ram_waddr          = r_cnt[AW-1:0];
        ram_wdata.task_id  = i_in_item.task_id;
        ram_wdata.deadline = i_in_item.task_deadline;
        ram_wdata.period   = i_in_item.task_period;
        ram_re             = 1'b0;
        ram_raddr          = r_rd_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res.dispatch_valid  = 1'b0;
                    n_res.dispatched_task = 4'd0;
                    n_res.queue_count     = 4'(r_cnt);
                    n_res.enqueue_dropped = 1'b0;
                    n_state               = S_EMIT;
                    if (i_in_item.command == CMD_ENQUEUE) begin
                        if (r_cnt < CNT_FULL) begin
                            ram_we            = 1'b1;
                            n_cnt             = r_cnt + CW'(1);
                            n_res.queue_count = 4'(r_cnt + CW'(1));
                        end else begin
                            n_res.enqueue_dropped = 1'b1;
                        end
                    end else if (!i_in_item.cpu_busy && r_cnt != '0) begin
                        n_rd_ptr   = '0;
                        n_key_sel  = (i_policy == POLICY_EDF);
                        n_scan_len = (i_policy == POLICY_EDF || i_policy == POLICY_RM)
                                     ? r_cnt : CW'(1);
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_ptr < r_scan_len) begin
                    ram_re   = 1'b1;
                    n_rd_ptr = r_rd_ptr + CW'(1);
                    n_dv     = 1'b1;
                    n_dv_ptr = r_rd_ptr[AW-1:0];
                end
                if (r_dv) begin
                    // first entry seeds the minimum, later ones replace it only when smaller
                    if (r_dv_ptr == '0 || rd_key < r_best_key) begin
                        n_best_key  = rd_key;
                        n_best_idx  = r_dv_ptr;
                        n_best_task = rd_entry.task_id;
                    end
                    if (CW'(r_dv_ptr) + CW'(1) == r_scan_len) begin
                        n_rd_ptr = CW'(n_best_idx) + CW'(1);
                        n_dv     = 1'b0;
                        n_state  = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (r_rd_ptr < r_cnt) begin
                    ram_re   = 1'b1;
                    n_rd_ptr = r_rd_ptr + CW'(1);
                    n_dv     = 1'b1;
                    n_dv_ptr = r_rd_ptr[AW-1:0];
                end
                if (r_dv) begin
                    // move entry down one slot, write always trails the read
                    ram_we    = 1'b1;
                    ram_waddr = r_dv_ptr - AW'(1);
                    ram_wdata = rd_entry;
                end else if (r_rd_ptr >= r_cnt) begin
                    n_cnt                 = r_cnt - CW'(1);
                    n_res.dispatch_valid  = 1'b1;
                    n_res.dispatched_task = r_best_task;
                    n_res.queue_count     = 4'(r_cnt - CW'(1));
                    n_res.enqueue_dropped = 1'b0;
                    n_state               = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr    <= n_rd_ptr;
        r_dv_ptr    <= n_dv_ptr;
        r_scan_len  <= n_scan_len;
        r_key_sel   <= n_key_sel;
        r_best_key  <= n_best_key;
        r_best_idx  <= n_best_idx;
        r_best_task <= n_best_task;
        r_res       <= n_res;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_res      = {(r_state == S_EMIT), r_res};

endmodule

`default_nettype wire

// ===== hw/rtl/ready_queue_dispatch_selector.sv =====
// top level of the ready queue dispatch selector
//
//  channel  dir  handshake          payload
//  i_in     in   valid/ready        command, task_id, task_deadline, task_period, cpu_busy
//  o_out    out  valid/ready        dispatch_valid, dispatched_task, queue_count, enqueue_dropped
//  i_cfg    in   write enable only  policy_mode (2 bits)
//
//  one item in flight; an enqueue or a refused schedule goes from idle to the emit state, then to the output register
//  a dispatch does one ram read per cycle for the key scan
//  (one read under fcfs), then one read and one write per cycle to close up the queue
//  reset empties the queue and selects fcfs; entry contents are not cleared
//  a held result in the output register does not block the next transfer on i_in
`default_nettype none

module ready_queue_dispatch_selector #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rqds_in_if.sink          i_in,
    rqds_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata
);
    import rqds_pkg::*;

    logic [1:0] r_policy_mode;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic       eng_in_ready;
    t_eng_res   eng_res;
    logic       res_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_mode <= POLICY_FCFS;
        end else if (i_cfg_we) begin
            r_policy_mode <= i_cfg_wdata;
        end
    end

    rqds_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_item  (i_in.data),
        .o_in_ready (eng_in_ready),
        .i_policy   (r_policy_mode),
        .o_res      (eng_res),
        .i_res_take (res_take)
    );

    assign i_in.ready = eng_in_ready;
    assign res_take   = eng_res.valid && (!r_out_valid || o_out.ready);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_item <= eng_res.item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

`ifndef SYNTHESIS
    a_ready_excl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(eng_in_ready && eng_res.valid))
        else $error("engine ready while a result is pending");

    a_take_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> r_out_valid)
        else $error("result taken but output register empty");

    a_dispatch_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.dispatch_valid) |-> !r_out_item.enqueue_dropped)
        else $error("dispatch and drop flagged together");

    a_idle_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.dispatch_valid)
            |-> (r_out_item.dispatched_task == 4'd0))
        else $error("task id nonzero without dispatch");
`endif

endmodule

`default_nettype wire
